### rtl/fip_pkg.sv
// Shared types, constants and helpers for the binary64 integer power block.
// Used by fip_fpu and fp64_integer_power; depends on nothing else.
package fip_pkg;

    localparam int EXP_WIDTH = 32;
    localparam int BIT_W     = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

    localparam logic [63:0] FP_ONE    = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [62:0] POS_INF   = 63'h7FF0_0000_0000_0000;

    typedef enum logic {
        FOP_MUL,
        FOP_DIV
    } t_fop;

    typedef struct packed {
        logic        start;
        t_fop        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fpu_rsp;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM_A,
        F_NORM_B,
        F_MUL,
        F_DIV,
        F_POST,
        F_SHR,
        F_ROUND
    } t_fstate;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQW,
        S_MB,
        S_MBW,
        S_NEXT,
        S_FIN,
        S_DIVW,
        S_OUT
    } t_state;

    function automatic logic fip_is_nan(input logic [63:0] v);
        return v[62:0] > POS_INF;
    endfunction

endpackage

### rtl/fp64_integer_power.sv
// Top level: binary64 base raised to a signed integer power by square-and-multiply.
// Sequencer around the shared unit fip_fpu; depends on fip_pkg.
//
//  channel   dir  signals                          fields (low bit up)
//  s_axis    in   s_axis_tvalid/tready/tdata[95:0] base_bits[63:0], power[95:64]
//  m_axis    out  m_axis_tvalid/tready/tdata[63:0] result_bits[63:0]
//
// One item at a time: each exponent bit takes a square and, if the bit is set, a multiply
// on the shared unit; these are skipped while the accumulator is still 1.0. A negative
// power adds a reciprocal on the shared unit, unless the accumulator is zero or NaN, and
// each leading zero bit of a subnormal operand adds a normalization step. Reset is
// synchronous and clears only control state. A result beat holds until m_axis_tready;
// no input is taken then.
module fp64_integer_power (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // base_bits[63:0], power[95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // result_bits[63:0]
);
    import fip_pkg::*;

    t_state                 r_state, n_state;
    logic [63:0]            r_x, n_x;
    logic [63:0]            r_acc, n_acc;
    logic [EXP_WIDTH-1:0]   r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [63:0]            r_res, n_res;
    t_fpu_req               fpu_req;
    t_fpu_rsp               fpu_rsp;

    fip_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x   <= n_x;
        r_acc <= n_acc;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_bit <= n_bit;
        r_res <= n_res;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_res;

    always_comb begin
        logic signed [EXP_WIDTH-1:0] p;
        logic                        acc_one;

        n_state = r_state;
        n_x     = r_x;
        n_acc   = r_acc;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_bit   = r_bit;
        n_res   = r_res;
        fpu_req = '{start: 1'b0, op: FOP_MUL, a: r_acc, b: r_acc};

        p       = EXP_WIDTH'($signed(s_axis_tdata[95:64]));
        acc_one = (r_acc == FP_ONE);

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_x     = s_axis_tdata[63:0];
                    n_neg   = p[EXP_WIDTH-1];
                    // The magnitude is read as unsigned, so the most negative power works.
                    n_mag   = p[EXP_WIDTH-1] ? (~p + EXP_WIDTH'(1)) : p;
                    n_acc   = FP_ONE;
                    n_bit   = BIT_W'(EXP_WIDTH - 1);
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (acc_one) begin
                    n_state = S_MB;
                end else begin
                    fpu_req.start = 1'b1;
                    n_state       = S_SQW;
                end
            end
            S_SQW: begin
                if (fpu_rsp.done) begin
                    n_acc   = fpu_rsp.res;
                    n_state = S_MB;
                end
            end
            S_MB: begin
                if (!r_mag[r_bit]) begin
                    n_state = S_NEXT;
                end else if (acc_one) begin
                    // 1.0 times the base is the base itself.
                    n_acc   = r_x;
                    n_state = S_NEXT;
                end else begin
                    fpu_req.start = 1'b1;
                    fpu_req.b     = r_x;
                    n_state       = S_MBW;
                end
            end
            S_MBW: begin
                if (fpu_rsp.done) begin
                    n_acc   = fpu_rsp.res;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_bit == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_bit   = r_bit - BIT_W'(1);
                    n_state = S_SQ;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
                if (fip_is_nan(r_acc)) begin
                    n_res = CANON_NAN;
                end else if (!r_neg) begin
                    n_res = r_acc;
                end else if (r_acc[62:0] == 63'd0) begin
                    n_res = {r_acc[63], POS_INF};
                end else begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FOP_DIV;
                    fpu_req.a     = FP_ONE;
                    fpu_req.b     = r_acc;
                    n_state       = S_DIVW;
                end
            end
            S_DIVW: begin
                if (fpu_rsp.done) begin
                    n_res   = fip_is_nan(fpu_rsp.res) ? CANON_NAN : fpu_rsp.res;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/fip_fpu.sv
// Iterative binary64 multiply and divide unit, round to nearest even.
// Multiply takes four 27x27 partial products; divide is restoring, one bit a cycle.
// Depends on fip_pkg.
module fip_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fip_pkg::t_fpu_req i_req,
    output fip_pkg::t_fpu_rsp o_rsp
);
    import fip_pkg::*;

    t_fstate      r_state, n_state;
    t_fop         r_op, n_op;
    logic         r_sign, n_sign;
    logic [52:0]  r_ma, n_ma, r_mb, n_mb;
    logic signed [13:0] r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [105:0] r_m, n_m;
    logic [53:0]  r_rem, n_rem;
    logic [54:0]  r_q, n_q;
    logic         r_sticky, n_sticky;
    logic [6:0]   r_cnt, n_cnt;
    logic [63:0]  r_res, n_res;
    logic         r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op     <= n_op;
        r_sign   <= n_sign;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_ea     <= n_ea;
        r_eb     <= n_eb;
        r_e      <= n_e;
        r_m      <= n_m;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_sticky <= n_sticky;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    always_comb begin
        logic [10:0]  ax, bx;
        logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic         sp_nan, sp_inf, sp_zero, sgn;
        logic [26:0]  pa, pb;
        logic [53:0]  prod;
        logic [105:0] addend;
        logic [13:0]  amt;
        logic [105:0] lost_mask;
        logic [52:0]  mant;
        logic [53:0]  mr;
        logic         up, st;
        logic signed [13:0] e_fin;
        logic [10:0]  xf;

        n_state  = r_state;
        n_op     = r_op;
        n_sign   = r_sign;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_ea     = r_ea;
        n_eb     = r_eb;
        n_e      = r_e;
        n_m      = r_m;
        n_rem    = r_rem;
        n_q      = r_q;
        n_sticky = r_sticky;
        n_cnt    = r_cnt;
        n_res    = r_res;
        n_done   = 1'b0;

        ax     = i_req.a[62:52];
        bx     = i_req.b[62:52];
        a_nan  = fip_is_nan(i_req.a);
        b_nan  = fip_is_nan(i_req.b);
        a_inf  = (i_req.a[62:0] == POS_INF);
        b_inf  = (i_req.b[62:0] == POS_INF);
        a_zero = (i_req.a[62:0] == 63'd0);
        b_zero = (i_req.b[62:0] == 63'd0);
        sgn    = i_req.a[63] ^ i_req.b[63];
        if (i_req.op == FOP_MUL) begin
            sp_nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
            sp_inf  = a_inf | b_inf;
            sp_zero = a_zero | b_zero;
        end else begin
            sp_nan  = a_nan | b_nan | (a_inf & b_inf) | (a_zero & b_zero);
            sp_inf  = a_inf | b_zero;
            sp_zero = a_zero | b_inf;
        end

        pa     = r_cnt[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        pb     = r_cnt[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
        prod   = 54'(pa) * 54'(pb);
        unique case (r_cnt[1:0])
            2'd0:    addend = 106'(prod);
            2'd3:    addend = 106'(prod) << 54;
            default: addend = 106'(prod) << 27;
        endcase

        amt       = 14'(14'sd1 - r_e);
        lost_mask = ~({106{1'b1}} << amt[6:0]);

        mant  = r_m[105:53];
        st    = (|r_m[51:0]) | r_sticky;
        up    = r_m[52] & (st | r_m[53]);
        mr    = {1'b0, mant} + 54'(up);
        e_fin = mr[53] ? r_e + 14'sd1 : r_e;
        xf    = (mr[53] || mr[52]) ? e_fin[10:0] : 11'd0;

        unique case (r_state)
            F_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_sign = sgn;
                    n_ma   = {ax != 11'd0, i_req.a[51:0]};
                    n_mb   = {bx != 11'd0, i_req.b[51:0]};
                    n_ea   = {3'b000, (ax == 11'd0) ? 11'd1 : ax};
                    n_eb   = {3'b000, (bx == 11'd0) ? 11'd1 : bx};
                    if (sp_nan) begin
                        n_res  = CANON_NAN;
                        n_done = 1'b1;
                    end else if (sp_inf) begin
                        n_res  = {sgn, POS_INF};
                        n_done = 1'b1;
                    end else if (sp_zero) begin
                        n_res  = {sgn, 63'd0};
                        n_done = 1'b1;
                    end else begin
                        n_state = F_NORM_A;
                    end
                end
            end
            F_NORM_A: begin
                // Subnormal operands are brought up to a leading one, a bit a cycle.
                if (!r_ma[52]) begin
                    n_ma = {r_ma[51:0], 1'b0};
                    n_ea = r_ea - 14'sd1;
                end else begin
                    n_state = F_NORM_B;
                end
            end
            F_NORM_B: begin
                if (!r_mb[52]) begin
                    n_mb = {r_mb[51:0], 1'b0};
                    n_eb = r_eb - 14'sd1;
                end else begin
                    n_cnt    = 7'd0;
                    n_m      = '0;
                    n_sticky = 1'b0;
                    n_rem    = {1'b0, r_ma};
                    n_q      = '0;
                    if (r_op == FOP_MUL) begin
                        n_e     = r_ea + r_eb - 14'sd1022;
                        n_state = F_MUL;
                    end else begin
                        n_e     = r_ea - r_eb + 14'sd1023;
                        n_state = F_DIV;
                    end
                end
            end
            F_MUL: begin
                n_m   = r_m + addend;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = F_POST;
                end
            end
            F_DIV: begin
                if (r_rem >= {1'b0, r_mb}) begin
                    n_rem = 54'((r_rem - {1'b0, r_mb}) << 1);
                    n_q   = {r_q[53:0], 1'b1};
                end else begin
                    n_rem = 54'(r_rem << 1);
                    n_q   = {r_q[53:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd54) begin
                    n_state = F_POST;
                end
            end
            F_POST: begin
                if (r_op == FOP_DIV) begin
                    // Quotient sits with its unit bit at the top; the remainder is sticky.
                    n_m = {r_q, r_rem != 54'd0, 50'd0};
                    if (!r_q[54]) begin
                        n_m = {r_q[53:0], r_rem != 54'd0, 51'd0};
                        n_e = r_e - 14'sd1;
                    end
                end else if (!r_m[105]) begin
                    n_m = {r_m[104:0], 1'b0};
                    n_e = r_e - 14'sd1;
                end
                n_state = F_SHR;
            end
            F_SHR: begin
                // Results below the normal range are denormalized in one shift.
                if (r_e < 14'sd1) begin
                    if (amt > 14'd107) begin
                        n_m      = '0;
                        n_sticky = |r_m;
                    end else begin
                        n_m      = r_m >> amt[6:0];
                        n_sticky = |(r_m & lost_mask);
                    end
                    n_e = 14'sd1;
                end
                n_state = F_ROUND;
            end
            F_ROUND: begin
                if (e_fin >= 14'sd2047) begin
                    n_res = {r_sign, POS_INF};
                end else begin
                    n_res = {r_sign, xf, mr[53] ? 52'd0 : mr[51:0]};
                end
                n_done  = 1'b1;
                n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

endmodule

### sim/tb.sv
// Testbench for fp64_integer_power: binary64 base raised to a signed 32-bit power.
// Depends on fip_pkg and the RTL top level; results are predicted with real arithmetic.
`timescale 1ns / 100ps

module tb;
    import fip_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;     // base_bits[63:0], power[95:64]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // result_bits[63:0]

    logic [63:0] expected_results[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    bit          idling_on = 1'b1;
    int          ready_hold = 0;

    fp64_integer_power uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit nan_pattern(input logic [63:0] v);
        return v[62:0] > POS_INF;
    endfunction

    // Square-and-multiply over all exponent bits; host doubles round to nearest even.
    function automatic logic [63:0] raise_to_power(input logic [63:0] base_bits,
                                                   input logic [31:0] power);
        real         x;
        real         acc;
        logic [31:0] mag;
        logic [63:0] acc_bits;
        logic [63:0] res;
        x   = $bitstoreal(base_bits);
        acc = 1.0;
        mag = power[31] ? (~power + 32'd1) : power;
        for (int i = EXP_WIDTH - 1; i >= 0; i--) begin
            acc = acc * acc;
            if (mag[i]) acc = acc * x;
        end
        acc_bits = $realtobits(acc);
        if (!power[31]) begin
            res = acc_bits;
        end else if (acc_bits[62:0] == 63'd0) begin
            res = {acc_bits[63], POS_INF};
        end else if (nan_pattern(acc_bits)) begin
            res = CANON_NAN;
        end else begin
            res = $realtobits(1.0 / acc);
        end
        if (nan_pattern(res)) res = CANON_NAN;
        return res;
    endfunction

    task automatic send_power(input logic [63:0] base_bits, input logic [31:0] power);
        int gap;
        gap = idling_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {power, base_bits};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(raise_to_power(base_bits, power));
        items_sent++;
    endtask

    // Result side: check each beat, then, while idling is on, stall for a random count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                int n;
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat 0x%016h", m_axis_tdata);
                    mismatches++;
                end else begin
                    logic [63:0] want;
                    want = expected_results.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("result_bits: expected 0x%016h, actual 0x%016h",
                               want, m_axis_tdata);
                        mismatches++;
                    end
                    results_checked++;
                end
                n = idling_on ? $urandom_range(0, 16) : 0;
                ready_hold    <= n;
                m_axis_tready <= (n == 0);
            end else if (ready_hold != 0) begin
                ready_hold    <= ready_hold - 1;
                m_axis_tready <= (ready_hold == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] random_base();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: b[62:52] = 11'h000;                        // zero or subnormal
            1: b[62:52] = 11'h7FF;                        // infinity or NaN
            2: b[62:0]  = 63'd0;
            3, 4, 5: b[62:52] = 11'(1023 + $urandom_range(0, 6) - 3);  // near one
            default: ;
        endcase
        return b;
    endfunction

    task automatic test_directed();
        logic [63:0] bases[8];
        bases = '{64'h7FF8_0000_0000_0001, 64'h0000_0000_0000_0000,
                  64'h8000_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                  64'h0000_0000_0000_0001, 64'h4000_0000_0000_0000,
                  64'hBFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF};
        foreach (bases[k]) send_power(bases[k], 32'd0);
        send_power(64'h4000_0000_0000_0000, 32'h7FFF_FFFF);
        send_power(64'h3FF0_0000_0000_0001, 32'h8000_0000);
        send_power(64'hBFF0_0000_0000_0000, 32'h8000_0000);
        send_power(64'h8000_0000_0000_0000, -32'sd3);
        send_power(64'h0000_0000_0000_0000, -32'sd2);
        send_power(64'h0000_0000_0000_0001, -32'sd1);
        send_power(64'h0000_0000_0000_0003, 32'd2);
        send_power(64'hFFF0_0000_0000_0000, -32'sd1);
        send_power(64'h7FF0_0000_0000_0000, 32'd0);
        send_power(64'hC000_0000_0000_0000, 32'd1023);
        send_power(64'h4000_0000_0000_0000, -32'sd1074);
        send_power(64'h7FF4_0000_0000_0000, -32'sd5);
        send_power(64'h3FF8_0000_0000_0000, 32'hFFFF_FFFF);
        send_power(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    endtask

    // Small powers, from -40 to 40, keep each item short.
    task automatic test_random_small(input int count);
        repeat (count) send_power(random_base(), $urandom_range(0, 80) - 40);
    endtask

    task automatic test_random_wide(input int count);
        repeat (count) send_power(random_base(), $urandom);
    endtask

    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        repeat (count) send_power(random_base(), $urandom_range(0, 2100) - 1050);
        idling_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_small(500);
        test_back_to_back(150);
        test_random_wide(100);
        test_random_small(80);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results, including zero, extreme and",
                 items_sent, results_checked);
        $display("special-value cases with and without idle cycles on both sides.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
